[rtl/e2q_pkg.sv]
package e2q_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int OUT_BITS     = FRAC_BITS + 2;
    localparam int CORDIC_STEPS = 27;
    localparam int CW           = 34;   // cordic datapath width, Q30 with headroom
    localparam int PW           = 96;   // product sum width

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);
    localparam logic signed [63:0]   PI_Q29      = 64'sd1686629713;

    typedef logic signed [CW-1:0] t_cw;

    typedef struct packed {
        t_cw x;
        t_cw y;
        t_cw z;
    } t_cordic;

    function automatic t_cw atan_q30(input int i);
        t_cw r;
        unique case (i)
            0:  r = CW'(32'h3243F6A8);
            1:  r = CW'(32'h1DAC6705);
            2:  r = CW'(32'h0FADBAFC);
            3:  r = CW'(32'h07F56EA6);
            4:  r = CW'(32'h03FEAB76);
            5:  r = CW'(32'h01FFD55B);
            6:  r = CW'(32'h00FFFAAA);
            7:  r = CW'(32'h007FFF55);
            8:  r = CW'(32'h003FFFEA);
            9:  r = CW'(32'h001FFFFD);
            10: r = CW'(32'h000FFFFF);
            default: r = CW'((64'sd1 <<< (30 - i)) - 64'sd1);
        endcase
        return r;
    endfunction

endpackage

[rtl/euler_angles_to_quaternion_top.sv]
// Channel | Direction | Signals
// input   | in        | i_valid, o_ready, i_roll_angle, i_pitch_angle, i_yaw_angle
// output  | out       | o_valid, i_ready, o_quat_w, o_quat_x, o_quat_y, o_quat_z
//
// One word per cycle while the output is not stalled; the pipeline is 1 angle scaling
// stage, 27 CORDIC steps, pair products, triple products, sum, round/saturate.
// The whole pipeline advances together when the output stage is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears only the valid bits.
module euler_angles_to_quaternion_top
    import e2q_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [ANGLE_BITS-1:0] i_roll_angle,
    input  logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [OUT_BITS-1:0]   o_quat_w,
    output logic signed [OUT_BITS-1:0]   o_quat_x,
    output logic signed [OUT_BITS-1:0]   o_quat_y,
    output logic signed [OUT_BITS-1:0]   o_quat_z
);

    localparam int LAT = CORDIC_STEPS + 5;

    logic           w_en;
    logic [LAT-1:0] r_vld;
    t_cw            w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;

    // whole pipe moves when the last slot is free or being taken
    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    e2q_cordic u_roll  (.i_clk, .i_en(w_en), .i_angle(i_roll_angle),  .o_cos(w_cx), .o_sin(w_sx));
    e2q_cordic u_pitch (.i_clk, .i_en(w_en), .i_angle(i_pitch_angle), .o_cos(w_cy), .o_sin(w_sy));
    e2q_cordic u_yaw   (.i_clk, .i_en(w_en), .i_angle(i_yaw_angle),   .o_cos(w_cz), .o_sin(w_sz));

    // pair products, rounded to Q30
    logic signed [2*CW-1:0] w_p0, w_p1, w_p2, w_p3;
    t_cw r_cxcy, r_sxsy, r_sxcy, r_cxsy, r_cz, r_sz;
    localparam logic signed [2*CW-1:0] HALF30 = (2*CW)'(1) <<< 29;

    assign w_p0 = (2*CW)'(w_cx) * (2*CW)'(w_cy) + HALF30;
    assign w_p1 = (2*CW)'(w_sx) * (2*CW)'(w_sy) + HALF30;
    assign w_p2 = (2*CW)'(w_sx) * (2*CW)'(w_cy) + HALF30;
    assign w_p3 = (2*CW)'(w_cx) * (2*CW)'(w_sy) + HALF30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cxcy <= CW'(w_p0 >>> 30);
            r_sxsy <= CW'(w_p1 >>> 30);
            r_sxcy <= CW'(w_p2 >>> 30);
            r_cxsy <= CW'(w_p3 >>> 30);
            r_cz   <= w_cz;
            r_sz   <= w_sz;
        end
    end

    // triple products, Q60, CW x CW signed
    logic signed [2*CW-1:0] r_t [8];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t[0] <= r_cxcy * r_cz;
            r_t[1] <= r_sxsy * r_sz;
            r_t[2] <= r_sxcy * r_cz;
            r_t[3] <= r_cxsy * r_sz;
            r_t[4] <= r_cxsy * r_cz;
            r_t[5] <= r_sxcy * r_sz;
            r_t[6] <= r_cxcy * r_sz;
            r_t[7] <= r_sxsy * r_cz;
        end
    end

    // sums, with rounding bias folded in
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (59 - FRAC_BITS);
    logic signed [PW-1:0] r_s [4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s[0] <= PW'(r_t[0]) + PW'(r_t[1]) + HALF;
            r_s[1] <= PW'(r_t[2]) - PW'(r_t[3]) + HALF;
            r_s[2] <= PW'(r_t[4]) + PW'(r_t[5]) + HALF;
            r_s[3] <= PW'(r_t[6]) - PW'(r_t[7]) + HALF;
        end
    end

    // round and saturate
    localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;
    logic signed [OUT_BITS-1:0] r_q [4];
    for (genvar g = 0; g < 4; g++) begin : g_fin
        logic signed [PW-1:0] w_v;
        logic signed [OUT_BITS-1:0] n_q;
        always_comb begin
            w_v = r_s[g] >>> (60 - FRAC_BITS);
            priority if (w_v > ONE) begin
                n_q = OUT_BITS'(ONE);
            end else if (w_v < -ONE) begin
                n_q = OUT_BITS'(-ONE);
            end else begin
                n_q = OUT_BITS'(w_v);
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q[g] <= n_q;
            end
        end
    end

    assign o_quat_w = r_q[0];
    assign o_quat_x = r_q[1];
    assign o_quat_y = r_q[2];
    assign o_quat_z = r_q[3];

endmodule

[rtl/e2q_cordic.sv]
// Pipelined half-angle cos/sin: angle scaling stage, then one CORDIC micro-rotation
// per stage. Advances when i_en is high.
module e2q_cordic
    import e2q_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output t_cw                          o_cos,
    output t_cw                          o_sin
);

    t_cordic r_st [CORDIC_STEPS+1];
    logic signed [63:0] w_h;
    logic signed [63:0] w_rad;

    // half angle (floor), to radians Q30, round half up
    always_comb begin
        w_h   = 64'(i_angle) >>> 1;
        w_rad = (w_h * PI_Q29 + (64'sd1 <<< (ANGLE_BITS - 3))) >>> (ANGLE_BITS - 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].x <= CORDIC_GAIN;
            r_st[0].y <= '0;
            r_st[0].z <= CW'(w_rad);
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        t_cordic n_st;
        always_comb begin
            if (!r_st[g].z[CW-1]) begin
                n_st.x = r_st[g].x - (r_st[g].y >>> g);
                n_st.y = r_st[g].y + (r_st[g].x >>> g);
                n_st.z = r_st[g].z - atan_q30(g);
            end else begin
                n_st.x = r_st[g].x + (r_st[g].y >>> g);
                n_st.y = r_st[g].y - (r_st[g].x >>> g);
                n_st.z = r_st[g].z + atan_q30(g);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g+1] <= n_st;
            end
        end
    end

    assign o_cos = r_st[CORDIC_STEPS].x;
    assign o_sin = r_st[CORDIC_STEPS].y;

endmodule

[tb/euler_angles_to_quaternion_checker.sv]
module euler_angles_to_quaternion_checker
    import e2q_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_in_ready,
    input  logic signed [ANGLE_BITS-1:0] i_roll_angle,
    input  logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    input  logic                         i_out_valid,
    input  logic                         i_ready,
    input  logic signed [OUT_BITS-1:0]   i_quat_w,
    input  logic signed [OUT_BITS-1:0]   i_quat_x,
    input  logic signed [OUT_BITS-1:0]   i_quat_y,
    input  logic signed [OUT_BITS-1:0]   i_quat_z,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [OUT_BITS-1:0] w, x, y, z;
    } t_quat;

    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F};

    t_quat quat_queue[$];

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // cos/sin of half the binary angle, Q30
    function automatic void half_trig(input logic signed [ANGLE_BITS-1:0] ang,
                                      output longint c, output longint s);
        longint h, z, x, y, dx, dy;
        h = longint'(ang) >>> 1;
        z = rnd_shift(h * 64'sd1686629713, ANGLE_BITS - 2);
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] round_sat(logic signed [127:0] q60);
        logic signed [127:0] v;
        v = (q60 + (128'sd1 <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
        if (v > (128'sd1 <<< FRAC_BITS)) v = 128'sd1 <<< FRAC_BITS;
        if (v < -(128'sd1 <<< FRAC_BITS)) v = -(128'sd1 <<< FRAC_BITS);
        return v[OUT_BITS-1:0];
    endfunction

    function automatic t_quat euler_to_quat(logic signed [ANGLE_BITS-1:0] r,
                                            logic signed [ANGLE_BITS-1:0] p,
                                            logic signed [ANGLE_BITS-1:0] yw);
        longint cx, sx, cy, sy, cz, sz, cxcy, sxsy, sxcy, cxsy;
        t_quat q;
        half_trig(r, cx, sx);
        half_trig(p, cy, sy);
        half_trig(yw, cz, sz);
        cxcy = rnd_shift(cx * cy, 30);
        sxsy = rnd_shift(sx * sy, 30);
        sxcy = rnd_shift(sx * cy, 30);
        cxsy = rnd_shift(cx * sy, 30);
        q.w = round_sat(128'(cxcy) * cz + 128'(sxsy) * sz);
        q.x = round_sat(128'(sxcy) * cz - 128'(cxsy) * sz);
        q.y = round_sat(128'(cxsy) * cz + 128'(sxcy) * sz);
        q.z = round_sat(128'(cxcy) * sz - 128'(sxsy) * cz);
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_quat q;
        if (i_rst_n) begin
            if (i_valid && i_in_ready)
                quat_queue.push_back(euler_to_quat(i_roll_angle, i_pitch_angle, i_yaw_angle));
            if (i_out_valid && i_ready) begin
                if (quat_queue.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    q = quat_queue.pop_front();
                    if (i_quat_w !== q.w) report_mismatch("w", i_quat_w, q.w);
                    if (i_quat_x !== q.x) report_mismatch("x", i_quat_x, q.x);
                    if (i_quat_y !== q.y) report_mismatch("y", i_quat_y, q.y);
                    if (i_quat_z !== q.z) report_mismatch("z", i_quat_z, q.z);
                end
            end
            o_pending = quat_queue.size();
        end
    end
endmodule

[tb/euler_angles_to_quaternion_top_test.sv]
module euler_angles_to_quaternion_top_test;
    import e2q_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1750;
    localparam int LATENCY    = 32;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [ANGLE_BITS-1:0] roll, pitch, yaw;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [OUT_BITS-1:0]   qw, qx, qy, qz;
    int                           fail_count;
    int                           pending;
    logic                         long_hold;   // receiver long stall request

    euler_angles_to_quaternion_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_quat_w(qw), .o_quat_x(qx), .o_quat_y(qy), .o_quat_z(qz)
    );

    euler_angles_to_quaternion_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .i_out_valid(out_valid), .i_ready(out_ready),
        .i_quat_w(qw), .i_quat_x(qx), .i_quat_y(qy), .i_quat_z(qz),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // interesting angles: extremes, quarter turns, near zero
    function automatic logic [ANGLE_BITS-1:0] pick_angle();
        logic [ANGLE_BITS-1:0] special [10] = '{16'h8000, 16'h7FFF, 16'h0000,
            16'hFFFF, 16'h0001, 16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h8001};
        if ($urandom_range(0, 4) == 0)
            return special[$urandom_range(0, 9)];
        return ANGLE_BITS'($urandom);
    endfunction

    // Offers one word, gap first, then holds it until accepted.
    // Valid stays high after acceptance so back-to-back words need no drop.
    task automatic send_word(logic [ANGLE_BITS-1:0] r, logic [ANGLE_BITS-1:0] p,
                             logic [ANGLE_BITS-1:0] yv, bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        roll     <= r;
        pitch    <= p;
        yaw      <= yv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls per word, plus one long hold-off on request
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) begin
                if (long_hold) break;
                @(posedge clk);
            end
        end
    end

    initial begin
        logic [ANGLE_BITS-1:0] dir_vals [6] = '{16'h8000, 16'h7FFF, 16'h0000,
            16'hFFFF, 16'h4000, 16'hC000};
        in_valid  = 1'b0;
        roll      = '0;
        pitch     = '0;
        yaw       = '0;
        rst_n     = 1'b0;
        long_hold = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes on each axis, all-equal extremes, mixed
        for (int i = 0; i < 6; i++) begin
            send_word(dir_vals[i], '0, '0, 1'b0);
            send_word('0, dir_vals[i], '0, 1'b0);
            send_word('0, '0, dir_vals[i], 1'b0);
        end
        send_word(16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_word(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        send_word(16'h4000, 16'hC000, 16'h2000, 1'b0);
        send_word(16'h5555, 16'hAAAA, 16'hFFFF, 1'b0);

        // pause until all results have come back
        wait_drain();

        // long receiver hold-off while words keep coming back to back
        long_hold = 1'b1;
        for (int i = 0; i < 60; i++)
            send_word(pick_angle(), pick_angle(), pick_angle(), 1'b0);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // stretches with no gaps
            send_word(pick_angle(), pick_angle(), pick_angle(), (i / 100) % 3 != 1);
            if (i == NUM_RANDOM / 2) wait_drain();
        end

        wait_drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("euler_angles_to_quaternion_top regression: pass");
        else
            $display("euler_angles_to_quaternion_top regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("euler_angles_to_quaternion_top regression: fail");
        $finish;
    end
endmodule
